[rtl/core/ordered_dither_palette_quantizer_macros.svh]
// assertion macros for the quantizer rtl
`ifndef ORDERED_DITHER_PALETTE_QUANTIZER_MACROS_SVH
`define ORDERED_DITHER_PALETTE_QUANTIZER_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define ODPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked on every clock edge, reset included
`define ODPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ODPQ_ASSERT(lbl, clk, rst, prop, msg)
`define ODPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/odpq_pkg.sv]
package odpq_pkg;

   typedef struct packed {
      logic        func;
      logic [11:0] col;
      logic [11:0] row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // item function codes
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // register indexes
   localparam logic CSR_DITHER_LEVEL = 1'b0;
   localparam logic CSR_PALETTE_USED = 1'b1;

   // dither level codes
   localparam logic [1:0] LEVEL_NONE    = 2'd0;
   localparam logic [1:0] LEVEL_QUARTER = 2'd1;
   localparam logic [1:0] LEVEL_HALF    = 2'd2;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
   localparam logic [7:0] CHAN_MAX     = 8'd255;
   localparam int         DIST_W       = 18;

   // 8x8 bayer matrix, row major
   localparam logic [5:0] BAYER8 [0:63] = '{
      6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
      6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
      6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
      6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
      6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
      6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
      6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
      6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
   };

   function automatic logic [5:0] scaled_threshold(input logic [1:0] level,
                                                   input logic [2:0] row3,
                                                   input logic [2:0] col3);
      logic [5:0] b;
      logic [6:0] q;
      logic [6:0] h;
      b = BAYER8[{row3, col3}];
      q = {1'b0, b} + 7'd2;
      h = {1'b0, b} + 7'd1;
      case (level)
         LEVEL_NONE:    scaled_threshold = 6'd0;
         LEVEL_QUARTER: scaled_threshold = {1'b0, q[6:2]};
         LEVEL_HALF:    scaled_threshold = h[6:1];
         default:       scaled_threshold = b;
      endcase
   endfunction

   function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [5:0] t);
      logic [8:0] s;
      s = {1'b0, v} + {3'b000, t};
      sat_add = s[8] ? CHAN_MAX : s[7:0];
   endfunction

endpackage

[rtl/core/odpq_ram.sv]
module odpq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ordered_dither_palette_quantizer.sv]
// Ordered-dither palette quantizer. Each item is a palette write (func 1) or a
// pixel (func 0). A palette write gives no result. A pixel with alpha below 255
// gives transparent black, which passes through the done state into the output
// register.
// An opaque pixel gets the 8x8 bayer threshold, scaled by the dither level, added
// per channel with saturation and is then compared against palette entries
// 0 .. palette_used-1 by one shared squared distance unit, one entry per cycle
// from the palette RAM's single read port (a count of 0 acts as 1, a count above
// PALETTE_DEPTH as PALETTE_DEPTH); no item is taken during the search. A
// finished result waits in the output register while the next item is taken.
// Palette entries must be written before a pixel search reads them.
`include "ordered_dither_palette_quantizer_macros.svh"

module ordered_dither_palette_quantizer
   import odpq_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [8:0] csr_wdata
);

   localparam int         AW        = $clog2(PALETTE_DEPTH);
   localparam logic [8:0] DEPTH_CNT = 9'(PALETTE_DEPTH);

   state_type state_ff, state_in;

   logic [1:0]        dither_level_ff;
   logic [8:0]        palette_used_ff;
   logic [AW-1:0]     issue_ff;
   logic              rd_valid_ff;
   logic              dist_valid_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [23:0]       dist_color_ff;
   logic [DIST_W-1:0] best_d_ff;
   logic [23:0]       best_color_ff;
   logic              opaque_ff;
   logic [7:0]        pix_r_ff, pix_g_ff, pix_b_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              req_accept;
   logic              pix_opaque;
   logic              pix_clear;
   logic              pal_write;
   logic              issue_en;
   logic              rsp_load;
   logic [8:0]        eff_cnt;
   logic [8:0]        last_full;
   logic [AW-1:0]     last_idx;
   logic [23:0]       rd_data;
   logic [5:0]        thresh;
   logic signed [8:0] dr, dg, db;
   logic [DIST_W-1:0] dist_in;

   assign req_accept = req_valid && !req_stall;
   assign pix_opaque = req_accept && (req_data.func == FUNC_PIXEL)
                       && (req_data.alpha == ALPHA_OPAQUE);
   assign pix_clear  = req_accept && (req_data.func == FUNC_PIXEL)
                       && (req_data.alpha != ALPHA_OPAQUE);
   assign pal_write  = req_accept && (req_data.func == FUNC_WRITE)
                       && ({1'b0, req_data.entry_index} < DEPTH_CNT);

   // number of entries searched, clamped to 1 .. PALETTE_DEPTH
   always_comb begin
      if (palette_used_ff == 9'd0) begin
         eff_cnt = 9'd1;
      end else if (palette_used_ff > DEPTH_CNT) begin
         eff_cnt = DEPTH_CNT;
      end else begin
         eff_cnt = palette_used_ff;
      end
      last_full = eff_cnt - 9'd1;
      last_idx  = last_full[AW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pix_opaque) begin
               state_in = ST_SEARCH;
            end else if (pix_clear) begin
               state_in = ST_DONE;
            end
         end
         ST_SEARCH: begin
            if (issue_ff == last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !dist_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      issue_en  = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_SEARCH: issue_en  = 1'b1;
         ST_DRAIN:  req_stall = 1'b1;
         ST_DONE:   rsp_load  = !rsp_valid_ff || !rsp_stall;
         default:   req_stall = 1'b1;
      endcase
   end

   odpq_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_write),
      .wr_addr (req_data.entry_index[AW-1:0]),
      .wr_data ({req_data.red, req_data.green, req_data.blue}),
      .rd_addr (issue_ff),
      .rd_data (rd_data)
   );

   assign thresh = scaled_threshold(dither_level_ff, req_data.row[2:0], req_data.col[2:0]);

   // shared squared distance unit
   always_comb begin
      logic signed [17:0] pr, pg, pb;
      dr = $signed({1'b0, rd_data[23:16]}) - $signed({1'b0, pix_r_ff});
      dg = $signed({1'b0, rd_data[15:8]})  - $signed({1'b0, pix_g_ff});
      db = $signed({1'b0, rd_data[7:0]})   - $signed({1'b0, pix_b_ff});
      pr = dr * dr;
      pg = dg * dg;
      pb = db * db;
      dist_in = DIST_W'($unsigned(pr)) + DIST_W'($unsigned(pg)) + DIST_W'($unsigned(pb));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         dither_level_ff <= LEVEL_NONE;
         palette_used_ff <= 9'd1;
         rd_valid_ff     <= 1'b0;
         dist_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         issue_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= issue_en;
         dist_valid_ff <= rd_valid_ff;
         if (pix_opaque) begin
            issue_ff <= '0;
         end else if (issue_en) begin
            issue_ff <= issue_ff + AW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_DITHER_LEVEL: dither_level_ff <= csr_wdata[1:0];
               CSR_PALETTE_USED: palette_used_ff <= csr_wdata;
               default:          dither_level_ff <= dither_level_ff;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pix_opaque) begin
         pix_r_ff  <= sat_add(req_data.red, thresh);
         pix_g_ff  <= sat_add(req_data.green, thresh);
         pix_b_ff  <= sat_add(req_data.blue, thresh);
         best_d_ff <= '1;
         opaque_ff <= 1'b1;
      end else if (pix_clear) begin
         best_color_ff <= '0;
         opaque_ff     <= 1'b0;
      end else if (dist_valid_ff && (dist_ff < best_d_ff)) begin
         // strict compare keeps the lowest index on a tie
         best_d_ff     <= dist_ff;
         best_color_ff <= dist_color_ff;
      end
      dist_ff       <= dist_in;
      dist_color_ff <= rd_data;
      if (rsp_load) begin
         rsp_data_ff.out_red   <= best_color_ff[23:16];
         rsp_data_ff.out_green <= best_color_ff[15:8];
         rsp_data_ff.out_blue  <= best_color_ff[7:0];
         rsp_data_ff.out_alpha <= opaque_ff ? ALPHA_OPAQUE : 8'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ODPQ_ASSERT(a_pipe_empty_idle, clock, reset, (state_ff == ST_IDLE) |-> (!rd_valid_ff && !dist_valid_ff), "search pipeline busy while idle")
   `ODPQ_ASSERT(a_issue_bound, clock, reset, (state_ff == ST_SEARCH) |-> (issue_ff <= last_idx), "palette read beyond searched count")
   `ODPQ_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "result raised outside done state")
   `ODPQ_ASSERT(a_opaque_search, clock, reset, pix_opaque |=> (state_ff == ST_SEARCH), "opaque pixel did not start a search")

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
   import odpq_pkg::*;
();

   localparam logic [1:0] LEVEL_FULL = 2'd3;
   localparam int         NUM_ENTRIES = 256;

   // holds the palette and register copy, predicts each pixel's color
   class palette_scoreboard;
      logic [23:0] palette [NUM_ENTRIES];
      logic [1:0]  level;
      logic [8:0]  used_count;
      rsp_type     expected_colors [$];
      int          errors;

      function new();
         level = LEVEL_NONE;
         used_count = 9'd1;
         errors = 0;
         foreach (palette[i]) palette[i] = '0;
      endfunction

      function void set_reg(input logic idx, input logic [8:0] value);
         if (idx == CSR_DITHER_LEVEL) level = value[1:0];
         else used_count = value;
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction

      function rsp_type nearest_color(input req_type px);
         rsp_type    res;
         logic [2:0] r3, c3, x3;
         int         bay, th, cr, cg, cb, n, best, best_d, d, dr, dg, db, i;
         res = '0;
         if (px.alpha != ALPHA_OPAQUE) return res;
         // recursive bayer build: interleave bits of row^col and row, lsb first
         r3 = px.row[2:0];
         c3 = px.col[2:0];
         x3 = r3 ^ c3;
         bay = {x3[0], r3[0], x3[1], r3[1], x3[2], r3[2]};
         case (level)
            LEVEL_NONE:    th = 0;
            LEVEL_QUARTER: th = (bay + 2) >> 2;
            LEVEL_HALF:    th = (bay + 1) >> 1;
            default:       th = bay;
         endcase
         cr = int'(px.red) + th;
         cg = int'(px.green) + th;
         cb = int'(px.blue) + th;
         if (cr > 255) cr = 255;
         if (cg > 255) cg = 255;
         if (cb > 255) cb = 255;
         n = (used_count > NUM_ENTRIES) ? NUM_ENTRIES : int'(used_count);
         best = 0;
         best_d = 1 << 30;
         for (i = 0; i < n; i++) begin
            dr = int'(palette[i][23:16]) - cr;
            dg = int'(palette[i][15:8]) - cg;
            db = int'(palette[i][7:0]) - cb;
            d = dr * dr + dg * dg + db * db;
            // strict compare keeps the lowest index on a tie
            if (d < best_d) begin
               best_d = d;
               best = i;
            end
         end
         res.out_red   = palette[best][23:16];
         res.out_green = palette[best][15:8];
         res.out_blue  = palette[best][7:0];
         res.out_alpha = ALPHA_OPAQUE;
         return res;
      endfunction

      function void note_item(input req_type it);
         if (it.func == FUNC_WRITE) palette[it.entry_index] = {it.red, it.green, it.blue};
         else expected_colors.push_back(nearest_color(it));
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= 100) $display("mismatch: %s", msg);
      endtask

      task check_result(input rsp_type got);
         rsp_type want;
         if (expected_colors.size() == 0) begin
            report($sformatf("result %h with no item waiting", got));
            return;
         end
         want = expected_colors.pop_front();
         if (got.out_red !== want.out_red)
            report($sformatf("out_red got %0d want %0d", got.out_red, want.out_red));
         if (got.out_green !== want.out_green)
            report($sformatf("out_green got %0d want %0d", got.out_green, want.out_green));
         if (got.out_blue !== want.out_blue)
            report($sformatf("out_blue got %0d want %0d", got.out_blue, want.out_blue));
         if (got.out_alpha !== want.out_alpha)
            report($sformatf("out_alpha got %0d want %0d", got.out_alpha, want.out_alpha));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_en = 1'b0;
   logic       csr_index = 1'b0;
   logic [8:0] csr_wdata = '0;

   palette_scoreboard quant = new();

   bit loaded [NUM_ENTRIES];
   int filled = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   ordered_dither_palette_quantizer DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] pick_chan();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'($urandom_range(240, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(input req_type it);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      quant.note_item(it);
   endtask

   task automatic write_entry(input logic [7:0] idx, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
      req_type it;
      it.func        = FUNC_WRITE;
      it.col         = 12'($urandom_range(0, 4095));
      it.row         = 12'($urandom_range(0, 4095));
      it.alpha       = 8'($urandom_range(0, 255));
      it.red         = r;
      it.green       = g;
      it.blue        = b;
      it.entry_index = idx;
      send_item(it);
      loaded[idx] = 1'b1;
      while (filled < NUM_ENTRIES && loaded[filled]) filled++;
   endtask

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] a, input logic [11:0] c, input logic [11:0] w);
      req_type it;
      it.func        = FUNC_PIXEL;
      it.col         = c;
      it.row         = w;
      it.red         = r;
      it.green       = g;
      it.blue        = b;
      it.alpha       = a;
      it.entry_index = 8'($urandom_range(0, 255));
      send_item(it);
   endtask

   // sender holds off until every pending color has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (quant.pending() != 0) @(posedge clock);
   endtask

   task automatic program_regs(input logic [1:0] lvl, input logic [8:0] cnt);
      logic [8:0] lvl_word;
      lvl_word = {7'($urandom_range(0, 127)), lvl};
      settle();
      // a palette write gives no result, so settle does not wait for it
      repeat (8) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DITHER_LEVEL;
      csr_wdata    <= lvl_word;
      @(posedge clock);
      csr_index    <= CSR_PALETTE_USED;
      csr_wdata    <= cnt;
      @(posedge clock);
      csr_write_en <= 1'b0;
      quant.set_reg(CSR_DITHER_LEVEL, lvl_word);
      quant.set_reg(CSR_PALETTE_USED, cnt);
   endtask

   initial begin
      #15_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : rsp_side
      int hold;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         hold = rsp_burst ? 0 : $urandom_range(0, 13);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         quant.check_result(rsp_data);
      end
   end

   initial begin : stimulus
      int         phase, i, count, sel;
      logic [1:0] lvl;
      logic [8:0] used;
      logic [7:0] idx;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: no dither, one entry searched
      write_entry(8'd0, 8'd10, 8'd20, 8'd30);
      send_pixel(8'd255, 8'd255, 8'd255, ALPHA_OPAQUE, 12'd0, 12'd0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd254, 12'd0, 12'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095);
      write_entry(8'd1, 8'd255, 8'd255, 8'd255);
      write_entry(8'd2, 8'd0, 8'd0, 8'd0);
      write_entry(8'd3, 8'd10, 8'd20, 8'd30);
      write_entry(8'd4, 8'd255, 8'd0, 8'd0);
      write_entry(8'd255, 8'd0, 8'd255, 8'd0);

      program_regs(LEVEL_FULL, 9'd5);
      send_pixel(8'd0, 8'd0, 8'd0, ALPHA_OPAQUE, 12'd4095, 12'd4095);
      // saturation on every channel
      send_pixel(8'd255, 8'd255, 8'd255, ALPHA_OPAQUE, 12'd0, 12'd3);
      // exact tie between entries 0 and 3
      send_pixel(8'd10, 8'd20, 8'd30, ALPHA_OPAQUE, 12'd0, 12'd0);
      send_pixel(8'd250, 8'd5, 8'd5, ALPHA_OPAQUE, 12'd1, 12'd0);
      send_pixel(8'd250, 8'd5, 8'd5, 8'd254, 12'd1, 12'd0);

      // zero count still returns entry 0
      program_regs(LEVEL_QUARTER, 9'd0);
      send_pixel(8'd255, 8'd255, 8'd255, ALPHA_OPAQUE, 12'd1, 12'd1);
      send_pixel(8'd0, 8'd0, 8'd0, ALPHA_OPAQUE, 12'd4095, 12'd0);

      program_regs(LEVEL_HALF, 9'd4);
      send_pixel(8'd0, 8'd0, 8'd0, ALPHA_OPAQUE, 12'd4, 12'd3);
      send_pixel(8'd255, 8'd0, 8'd0, ALPHA_OPAQUE, 12'd2, 12'd5);
      send_pixel(8'd128, 8'd128, 8'd128, ALPHA_OPAQUE, 12'd7, 12'd6);

      for (phase = 0; phase < 12; phase++) begin
         lvl = 2'($urandom_range(0, 3));
         case (phase)
            0:       begin lvl = LEVEL_NONE; used = 9'(filled); end
            1:       begin lvl = LEVEL_FULL; used = 9'($urandom_range(1, filled)); end
            2:       used = 9'($urandom_range(2, filled));
            5:       used = 9'd256;
            8:       used = 9'd511;
            9:       used = 9'd0;
            10:      used = 9'($urandom_range(257, 510));
            11:      used = 9'd1;
            default: used = 9'($urandom_range(1, (filled < 24) ? filled : 24));
         endcase
         program_regs(lvl, used);
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);

         // fill the whole palette so large counts read only written entries
         if (phase == 2)
            for (i = 0; i < NUM_ENTRIES; i++)
               write_entry(8'(i), pick_chan(), pick_chan(), pick_chan());

         count = (used > 24) ? 40 : 80;
         for (i = 0; i < count; i++) begin
            if (i == count / 2) settle();
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
               idx = ($urandom_range(0, 1) == 1 && filled < NUM_ENTRIES) ?
                     8'(filled) : 8'($urandom_range(0, 255));
               write_entry(idx, pick_chan(), pick_chan(), pick_chan());
            end else if (sel < 35) begin
               send_pixel(pick_chan(), pick_chan(), pick_chan(), 8'($urandom_range(0, 254)),
                          12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            end else begin
               send_pixel(pick_chan(), pick_chan(), pick_chan(), ALPHA_OPAQUE,
                          12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (quant.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (quant.errors == 0 && quant.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/odpq_pkg.sv
rtl/core/odpq_ram.sv
rtl/core/ordered_dither_palette_quantizer.sv
test/tb_top.sv
